// ===== rtl/sbm_pkg.sv =====
// Shared constants, types and state codes for the shifting Bloom membership block.
package sbm_pkg;

    localparam int HASH_W         = 64;
    localparam int MOD_W          = 13;
    localparam int NH_W           = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int DIGITS         = 4;
    localparam int PREP_CYCLES    = HASH_W / DIGITS;
    localparam int CNT_W          = $clog2(PREP_CYCLES);

    localparam int BITS_MAX_DEF   = 4096;
    localparam int SHIFT_SPAN_DEF = 57;
    localparam int HASHES_MAX_DEF = 16;

    localparam logic [MOD_W-1:0] NUM_BITS_RST   = 13'd4096;
    localparam logic [NH_W-1:0]  NUM_HASHES_RST = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_ADV,
        ST_PROBE,
        ST_STEP,
        ST_DONE
    } state_t;

    // remainders handed from the reduction unit to the sequencer
    typedef struct packed {
        logic [MOD_W-1:0] lo_rem;
        logic [MOD_W-1:0] hi_rem;
        logic [MOD_W-1:0] wrap_rem;
    } mod_res_t;

endpackage

// ===== rtl/sbm_reduce.sv =====
// Radix-16 remainder unit: hash words mod m, 2^64 mod m and the pair shift.
module sbm_reduce #(
    parameter int SHIFT_SPAN = sbm_pkg::SHIFT_SPAN_DEF,
    localparam int SW = $clog2(SHIFT_SPAN)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sbm_pkg::HASH_W-1:0]     hash_low,
    input  logic [sbm_pkg::HASH_W-1:0]     hash_high,
    input  logic [sbm_pkg::MOD_W-1:0]      m_eff,
    output logic                           done,
    output sbm_pkg::mod_res_t              res,
    output logic [SW-1:0]                  shift
);

    localparam int DIV = SHIFT_SPAN - 1;

    logic [sbm_pkg::HASH_W-1:0] lo_sh_reg;
    logic [sbm_pkg::HASH_W-1:0] hi_sh_reg;
    logic [sbm_pkg::MOD_W-1:0]  lo_r_reg, lo_r_next;
    logic [sbm_pkg::MOD_W-1:0]  hi_r_reg, hi_r_next;
    logic [sbm_pkg::MOD_W-1:0]  w_r_reg, w_r_next;
    logic [SW-1:0]              s_r_reg, s_r_next;
    logic [sbm_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    function automatic logic [sbm_pkg::MOD_W-1:0] mstep(
        input logic [sbm_pkg::MOD_W-1:0] r,
        input logic                      b,
        input logic [sbm_pkg::MOD_W-1:0] m
    );
        logic [sbm_pkg::MOD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[sbm_pkg::MOD_W-1:0];
    endfunction

    function automatic logic [SW-1:0] sstep(
        input logic [SW-1:0] r,
        input logic          b
    );
        logic [SW:0] t;
        t = {r, b};
        if (t >= (SW+1)'(DIV))
        begin
            t = t - (SW+1)'(DIV);
        end
        return t[SW-1:0];
    endfunction

    // four MSB-first bits per cycle on every lane
    always_comb
    begin
        lo_r_next = lo_r_reg;
        hi_r_next = hi_r_reg;
        w_r_next  = w_r_reg;
        s_r_next  = s_r_reg;
        for (int j = 0; j < sbm_pkg::DIGITS; j++)
        begin
            lo_r_next = mstep(lo_r_next, lo_sh_reg[sbm_pkg::HASH_W-1-j], m_eff);
            hi_r_next = mstep(hi_r_next, hi_sh_reg[sbm_pkg::HASH_W-1-j], m_eff);
            w_r_next  = mstep(w_r_next, 1'b0, m_eff);
            s_r_next  = sstep(s_r_next, lo_sh_reg[sbm_pkg::HASH_W-1-j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sbm_pkg::CNT_W'(sbm_pkg::PREP_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // 2^64 mod m: start from 1 mod m, then 64 doublings
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_sh_reg <= hash_low;
            hi_sh_reg <= hash_high;
            lo_r_reg  <= '0;
            hi_r_reg  <= '0;
            w_r_reg   <= (m_eff == sbm_pkg::MOD_W'(1)) ? '0 : sbm_pkg::MOD_W'(1);
            s_r_reg   <= '0;
        end
        else if (busy_reg)
        begin
            lo_sh_reg <= lo_sh_reg << sbm_pkg::DIGITS;
            hi_sh_reg <= hi_sh_reg << sbm_pkg::DIGITS;
            lo_r_reg  <= lo_r_next;
            hi_r_reg  <= hi_r_next;
            w_r_reg   <= w_r_next;
            s_r_reg   <= s_r_next;
        end
    end

    assign done         = done_reg;
    assign res.lo_rem   = lo_r_reg;
    assign res.hi_rem   = hi_r_reg;
    assign res.wrap_rem = w_r_reg;
    assign shift        = s_r_reg + SW'(1);

endmodule

// ===== rtl/sbm_store.sv =====
// Single-bit filter store: one write port, two registered read ports.
module sbm_store #(
    parameter int DEPTH = sbm_pkg::BITS_MAX_DEF + sbm_pkg::SHIFT_SPAN_DEF - 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic          rdata_a,
    output logic          rdata_b
);

    logic mem [DEPTH];
    logic rdata_a_reg;
    logic rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/sbm_ctrl.sv =====
// Sequencer: store clearing pass, probe index stepping, bit pair access and result register.
module sbm_ctrl #(
    parameter int BITS_MAX   = sbm_pkg::BITS_MAX_DEF,
    parameter int SHIFT_SPAN = sbm_pkg::SHIFT_SPAN_DEF,
    parameter int HASHES_MAX = sbm_pkg::HASHES_MAX_DEF,
    localparam int DEPTH = BITS_MAX + SHIFT_SPAN - 1,
    localparam int AW    = $clog2(DEPTH),
    localparam int SW    = $clog2(SHIFT_SPAN),
    localparam int KW    = $clog2(HASHES_MAX + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  logic [sbm_pkg::HASH_W-1:0] hash_low,
    input  logic [sbm_pkg::HASH_W-1:0] hash_high,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       present,
    input  logic [sbm_pkg::MOD_W-1:0]  m_eff,
    input  logic [KW-1:0]              k_eff,
    output logic                       red_start,
    input  logic                       red_done,
    input  sbm_pkg::mod_res_t          red_res,
    input  logic [SW-1:0]              shift,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic                       mem_wdata,
    output logic [AW-1:0]              mem_raddr_a,
    output logic [AW-1:0]              mem_raddr_b,
    input  logic                       mem_rdata_a,
    input  logic                       mem_rdata_b
);

    sbm_pkg::state_t state_reg, state_next;

    logic [AW-1:0]              clr_reg;
    logic                       op_reg;
    logic [sbm_pkg::HASH_W-1:0] hi_reg;
    logic [sbm_pkg::HASH_W-1:0] h_reg;
    logic [sbm_pkg::MOD_W-1:0]  a_reg;
    logic [KW-1:0]              i_reg;
    logic                       all_set_reg;
    logic                       out_valid_reg;
    logic                       present_reg;

    logic [sbm_pkg::MOD_W-1:0]  a_src;
    logic [sbm_pkg::MOD_W-1:0]  a_adv;
    logic [sbm_pkg::HASH_W-1:0] h_sum;
    logic                       h_carry;
    logic [AW-1:0]              addr_a;
    logic [AW-1:0]              addr_b;
    logic                       last_probe;
    logic                       load_out;

    // next index: a + H mod m, minus 2^64 mod m when the 64-bit sum wrapped
    function automatic logic [sbm_pkg::MOD_W-1:0] adv_idx(
        input logic [sbm_pkg::MOD_W-1:0] a,
        input logic [sbm_pkg::MOD_W-1:0] h,
        input logic [sbm_pkg::MOD_W-1:0] w,
        input logic [sbm_pkg::MOD_W-1:0] m,
        input logic                      carry
    );
        logic [sbm_pkg::MOD_W:0] t;
        logic [sbm_pkg::MOD_W:0] u;
        t = {1'b0, a} + {1'b0, h};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        if (carry)
        begin
            if (t >= {1'b0, w})
            begin
                u = t - {1'b0, w};
            end
            else
            begin
                u = t + {1'b0, m} - {1'b0, w};
            end
        end
        else
        begin
            u = t;
        end
        return u[sbm_pkg::MOD_W-1:0];
    endfunction

    assign a_src              = (state_reg == sbm_pkg::ST_ADV) ? red_res.lo_rem : a_reg;
    assign {h_carry, h_sum}   = {1'b0, h_reg} + {1'b0, hi_reg};
    assign a_adv              = adv_idx(a_src, red_res.hi_rem, red_res.wrap_rem, m_eff, h_carry);
    assign addr_a             = AW'(a_reg);
    assign addr_b             = addr_a + AW'(shift);
    assign last_probe         = (i_reg == k_eff);
    assign load_out           = (state_reg == sbm_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbm_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = sbm_pkg::ST_IDLE;
                end
            end
            sbm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sbm_pkg::ST_PREP;
                end
            end
            sbm_pkg::ST_PREP:
            begin
                if (red_done)
                begin
                    state_next = sbm_pkg::ST_ADV;
                end
            end
            sbm_pkg::ST_ADV:
            begin
                state_next = sbm_pkg::ST_PROBE;
            end
            sbm_pkg::ST_PROBE:
            begin
                state_next = sbm_pkg::ST_STEP;
            end
            sbm_pkg::ST_STEP:
            begin
                if (!last_probe)
                begin
                    state_next = sbm_pkg::ST_PROBE;
                end
                else if (op_reg == sbm_pkg::OP_QUERY)
                begin
                    state_next = sbm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sbm_pkg::ST_IDLE;
                end
            end
            sbm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = sbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbm_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        red_start   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_a;
        mem_wdata   = 1'b1;
        mem_raddr_a = addr_a;
        mem_raddr_b = addr_b;
        unique case (state_reg)
            sbm_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
            end
            sbm_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                red_start = in_valid;
            end
            sbm_pkg::ST_PROBE:
            begin
                mem_we = (op_reg == sbm_pkg::OP_INSERT);
            end
            sbm_pkg::ST_STEP:
            begin
                mem_we    = (op_reg == sbm_pkg::OP_INSERT);
                mem_waddr = addr_b;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbm_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sbm_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sbm_pkg::ST_IDLE && in_valid)
        begin
            op_reg      <= opcode;
            hi_reg      <= hash_high;
            h_reg       <= hash_low;
            all_set_reg <= 1'b1;
        end
        if (state_reg == sbm_pkg::ST_ADV)
        begin
            a_reg <= a_adv;
            h_reg <= h_sum;
            i_reg <= KW'(1);
        end
        if (state_reg == sbm_pkg::ST_STEP)
        begin
            // read data here belongs to the pair addressed in the probe cycle
            if (op_reg == sbm_pkg::OP_QUERY && (!mem_rdata_a || !mem_rdata_b))
            begin
                all_set_reg <= 1'b0;
            end
            if (!last_probe)
            begin
                a_reg <= a_adv;
                h_reg <= h_sum;
                i_reg <= i_reg + 1'b1;
            end
        end
        if (load_out)
        begin
            present_reg <= all_set_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign present   = present_reg;

    ap_zero_only_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !mem_wdata) |-> (state_reg == sbm_pkg::ST_CLEAR))
        else $error("store bit cleared outside the clearing pass");

    ap_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sbm_pkg::ST_DONE && op_reg == sbm_pkg::OP_QUERY))
        else $error("result raised without a finished query");

    ap_probe_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbm_pkg::ST_PROBE) |-> (a_reg < m_eff && i_reg != '0 && i_reg <= k_eff))
        else $error("probe index or count out of range");

    ap_pair_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbm_pkg::ST_STEP) |-> (int'(addr_b) < DEPTH))
        else $error("shifted bit beyond the store");

endmodule

// ===== rtl/shifting_bloom_membership.sv =====
// Shifting Bloom filter membership block. After reset the bit store is swept to zero, one
// entry a cycle over all BITS_MAX + SHIFT_SPAN - 1 entries (4152 at default size); no item
// is taken in that time, while configuration writes are. The remainder unit then reduces
// both hash words, 2^64 and the shift modulus four bits a cycle and registers its done flag.
// The first index is formed in a state of its own (ADV). Each probe has a PROBE and a STEP
// state on the single write port: an insert writes both bits in turn, a query reads both at
// once and checks them. A query then loads its result in the DONE state, and every item ends
// with the idle state in which the next is taken. A query result waits in an output register,
// so the next item is taken while it is held; a query that finds that register still full
// and stalled waits until it drains.
module shifting_bloom_membership #(
    parameter int BITS_MAX   = sbm_pkg::BITS_MAX_DEF,
    parameter int SHIFT_SPAN = sbm_pkg::SHIFT_SPAN_DEF,
    parameter int HASHES_MAX = sbm_pkg::HASHES_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [sbm_pkg::HASH_W-1:0]    hash_low,
    input  logic [sbm_pkg::HASH_W-1:0]    hash_high,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          present,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbm_pkg::MOD_W-1:0]     cfg_data
);

    localparam int DEPTH = BITS_MAX + SHIFT_SPAN - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SHIFT_SPAN);
    localparam int KW    = $clog2(HASHES_MAX + 1);

    logic [sbm_pkg::MOD_W-1:0] num_bits_reg;
    logic [sbm_pkg::NH_W-1:0]  num_hashes_reg;
    logic [sbm_pkg::MOD_W-1:0] m_eff;
    logic [KW-1:0]             k_eff;

    logic                      red_start;
    logic                      red_done;
    sbm_pkg::mod_res_t         red_res;
    logic [SW-1:0]             shift;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic                      mem_wdata;
    logic [AW-1:0]             mem_raddr_a;
    logic [AW-1:0]             mem_raddr_b;
    logic                      mem_rdata_a;
    logic                      mem_rdata_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg   <= sbm_pkg::NUM_BITS_RST;
            num_hashes_reg <= sbm_pkg::NUM_HASHES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sbm_pkg::CFG_NUM_BITS:
                begin
                    num_bits_reg <= cfg_data;
                end
                sbm_pkg::CFG_NUM_HASHES:
                begin
                    num_hashes_reg <= cfg_data[sbm_pkg::NH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // zero means one; values above the store size saturate
    always_comb
    begin
        priority if (num_bits_reg == '0)
        begin
            m_eff = sbm_pkg::MOD_W'(1);
        end
        else if (int'(num_bits_reg) > BITS_MAX)
        begin
            m_eff = sbm_pkg::MOD_W'(BITS_MAX);
        end
        else
        begin
            m_eff = num_bits_reg;
        end
    end

    always_comb
    begin
        priority if (num_hashes_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(num_hashes_reg) > HASHES_MAX)
        begin
            k_eff = KW'(HASHES_MAX);
        end
        else
        begin
            k_eff = KW'(num_hashes_reg);
        end
    end

    sbm_reduce #(
        .SHIFT_SPAN (SHIFT_SPAN)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start),
        .hash_low  (hash_low),
        .hash_high (hash_high),
        .m_eff     (m_eff),
        .done      (red_done),
        .res       (red_res),
        .shift     (shift)
    );

    sbm_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    sbm_ctrl #(
        .BITS_MAX   (BITS_MAX),
        .SHIFT_SPAN (SHIFT_SPAN),
        .HASHES_MAX (HASHES_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .hash_low    (hash_low),
        .hash_high   (hash_high),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .present     (present),
        .m_eff       (m_eff),
        .k_eff       (k_eff),
        .red_start   (red_start),
        .red_done    (red_done),
        .red_res     (red_res),
        .shift       (shift),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

endmodule
